// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants shared by the text console writer modules.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int CHAR_W       = 8;
    localparam int ATTR_W       = 8;
    localparam int CELL_W       = CHAR_W + ATTR_W;
    localparam int CURSOR_COL_W = 7;
    localparam int CURSOR_ROW_W = 5;

    localparam logic [CHAR_W-1:0] NEWLINE_BYTE = 8'd10;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;
    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;

    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef struct packed {
        logic                    action;
        logic [CHAR_W-1:0]       char_code;
        logic [CURSOR_ROW_W-1:0] read_row;
        logic [CURSOR_COL_W-1:0] read_col;
    } t_item;

    typedef struct packed {
        logic [CHAR_W-1:0]       cell_char;
        logic [ATTR_W-1:0]       cell_attr;
        logic [CURSOR_COL_W-1:0] cursor_col;
        logic [CURSOR_ROW_W-1:0] cursor_row;
    } t_result;

    typedef struct packed {
        logic load;
        logic exec;
        logic clear;
        logic init;
    } t_dp_cmd;

    typedef struct packed {
        logic scroll;
        logic clear_last;
        logic init_last;
    } t_dp_stat;

endpackage

// ===== rtl/text_console_writer_with_scroll_unit.sv =====
// Timing: an accepted item runs through the execute state and then the result
// beat; a put that scrolls goes through the row clear state in between, which
// blanks the new bottom row. A new item can be accepted while the previous
// result beat is shown.
// Reset: synchronous; afterwards busy stays high while the screen is swept
// to blanks. Results cannot be stalled.
// ----------------------------------------------------------------------------
// text_console_writer_with_scroll_unit
// Character-cell text console with cursor, line wrap and scroll.
// ----------------------------------------------------------------------------
module text_console_writer_with_scroll_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_wdata,
    input  logic             start,
    output logic             busy,
    input  tcw_pkg::t_item   i_item,
    output logic             o_done,
    output tcw_pkg::t_result o_result
);

    tcw_pkg::t_dp_cmd  w_cmd;
    tcw_pkg::t_dp_stat w_stat;

    tcw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_item),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_result    (o_result)
    );

endmodule

// ===== rtl/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: reset clearing sweep, item execution, row clear on scroll and
// result beat.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output logic             o_done,
    output tcw_pkg::t_dp_cmd o_cmd,
    input  tcw_pkg::t_dp_stat i_stat
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_CLEAR,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign busy     = !((r_state == S_IDLE) || (r_state == S_RESP));
    assign w_accept = start && !busy;
    assign o_done   = (r_state == S_RESP);

    always_comb begin
        o_cmd       = '0;
        o_cmd.load  = w_accept;
        o_cmd.exec  = (r_state == S_EXEC);
        o_cmd.clear = (r_state == S_CLEAR);
        o_cmd.init  = (r_state == S_INIT);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (i_stat.init_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = i_stat.scroll ? S_CLEAR : S_RESP;
            end
            S_CLEAR: begin
                if (i_stat.clear_last) n_state = S_RESP;
            end
            S_RESP: begin
                n_state = w_accept ? S_EXEC : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/tcw_datapath.sv =====
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen memory kept as a ring of rows, cursor, attribute register and the
// cell address arithmetic. A scroll moves the top-row pointer and blanks one
// row.
// ----------------------------------------------------------------------------
module tcw_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata,
    input  tcw_pkg::t_item    i_item,
    input  tcw_pkg::t_dp_cmd  i_cmd,
    output tcw_pkg::t_dp_stat o_stat,
    output tcw_pkg::t_result  o_result
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int CELL_W     = tcw_pkg::CELL_W;
    localparam int CUR_COL_W  = tcw_pkg::CURSOR_COL_W;
    localparam int CUR_ROW_W  = tcw_pkg::CURSOR_ROW_W;

    typedef enum logic [1:0] {
        SEL_MEM,
        SEL_ZERO,
        SEL_BLANK
    } t_cell_sel;

    logic [CELL_W-1:0] r_mem [CELL_COUNT];
    logic [CELL_W-1:0] r_rdata;

    tcw_pkg::t_item    r_item;
    logic [7:0]        r_attr;
    logic [COL_W-1:0]  r_cur_col;
    logic [ROW_W-1:0]  r_cur_row;
    logic [ROW_W-1:0]  r_base;
    logic [ROW_W-1:0]  r_clr_row;
    logic [ADDR_W-1:0] r_cnt;
    t_cell_sel         r_sel;

    logic              w_put;
    logic              w_nl;
    logic              w_col_last;
    logic              w_row_last;
    logic              w_line_adv;
    logic              w_scroll;
    logic              w_in_range;
    logic [COL_W-1:0]  w_next_col;
    logic [ROW_W-1:0]  w_next_row;
    logic [ROW_W-1:0]  w_next_base;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [CELL_W-1:0] w_wdata;
    logic [ADDR_W-1:0] w_raddr;
    logic [CELL_W-1:0] w_cell;

    function automatic logic [ROW_W-1:0] f_phys(input logic [ROW_W-1:0] row,
                                               input logic [ROW_W-1:0] base);
        logic [ROW_W:0] sum;
        sum = {1'b0, row} + {1'b0, base};
        if (sum >= (ROW_W+1)'(ROWS)) sum = sum - (ROW_W+1)'(ROWS);
        return sum[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] f_addr(input logic [ROW_W-1:0] row,
                                                input logic [COL_W-1:0] col);
        return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

    // cursor step for a put
    assign w_put      = (r_item.action == tcw_pkg::ACT_PUT);
    assign w_nl       = (r_item.char_code == tcw_pkg::NEWLINE_BYTE);
    assign w_col_last = (r_cur_col == COL_W'(COLUMNS - 1));
    assign w_row_last = (r_cur_row == ROW_W'(ROWS - 1));
    assign w_line_adv = w_nl || w_col_last;
    assign w_scroll   = w_put && w_line_adv && w_row_last;
    assign w_next_col = w_line_adv ? '0 : r_cur_col + 1'b1;
    assign w_next_row = (w_line_adv && !w_row_last) ? r_cur_row + 1'b1 : r_cur_row;
    assign w_next_base = !w_scroll ? r_base :
                         (r_base == ROW_W'(ROWS - 1)) ? '0 : r_base + 1'b1;
    assign w_in_range = (32'(r_item.read_row) < 32'(ROWS))
                     && (32'(r_item.read_col) < 32'(COLUMNS));

    always_comb begin
        o_stat            = '0;
        o_stat.scroll     = w_scroll;
        o_stat.clear_last = (r_cnt == ADDR_W'(COLUMNS - 1));
        o_stat.init_last  = (r_cnt == ADDR_W'(CELL_COUNT - 1));
    end

    // single write port
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cnt;
        w_wdata = tcw_pkg::BLANK_CELL;
        if (i_cmd.init) begin
            w_we = 1'b1;
        end else if (i_cmd.clear) begin
            w_we    = 1'b1;
            w_waddr = f_addr(r_clr_row, COL_W'(r_cnt));
        end else if (i_cmd.exec && w_put && !w_nl) begin
            w_we    = 1'b1;
            w_waddr = f_addr(f_phys(r_cur_row, r_base), r_cur_col);
            w_wdata = {r_attr, r_item.char_code};
        end
    end

    always_comb begin
        if (w_put) begin
            w_raddr = f_addr(f_phys(w_next_row, w_next_base), w_next_col);
        end else if (w_in_range) begin
            w_raddr = f_addr(f_phys(ROW_W'(r_item.read_row), r_base),
                             COL_W'(r_item.read_col));
        end else begin
            w_raddr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr    <= tcw_pkg::ATTR_RESET;
            r_cur_col <= '0;
            r_cur_row <= '0;
            r_base    <= '0;
            r_cnt     <= '0;
        end else begin
            if (i_cfg_we) r_attr <= i_cfg_wdata;
            if (i_cmd.init) begin
                r_cnt <= o_stat.init_last ? '0 : r_cnt + 1'b1;
            end else if (i_cmd.clear) begin
                r_cnt <= o_stat.clear_last ? '0 : r_cnt + 1'b1;
            end
            if (i_cmd.exec && w_put) begin
                r_cur_col <= w_next_col;
                r_cur_row <= w_next_row;
                r_base    <= w_next_base;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= i_item;
        if (i_cmd.exec) begin
            r_clr_row <= r_base;
            if (w_scroll) begin
                r_sel <= SEL_BLANK;
            end else if (!w_put && !w_in_range) begin
                r_sel <= SEL_ZERO;
            end else begin
                r_sel <= SEL_MEM;
            end
        end
    end

    always_comb begin
        case (r_sel)
            SEL_MEM:   w_cell = r_rdata;
            SEL_ZERO:  w_cell = '0;
            SEL_BLANK: w_cell = tcw_pkg::BLANK_CELL;
            default:   w_cell = r_rdata;
        endcase
    end

    always_comb begin
        o_result            = '0;
        o_result.cell_char  = w_cell[7:0];
        o_result.cell_attr  = w_cell[CELL_W-1:8];
        o_result.cursor_col = CUR_COL_W'(r_cur_col);
        o_result.cursor_row = CUR_ROW_W'(r_cur_row);
    end

endmodule

// ===== tb/sv/text_console_writer_with_scroll_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_with_scroll_unit_tb
// Self-checking bench for the text console writer. Put and read beats are
// sent with random gaps. Each one is run through a local model of the screen,
// the cursor and the attribute register, and every result beat is compared
// with it or with a value given in the directed table, which is followed by
// random phases that each start with a new attribute value.
// ----------------------------------------------------------------------------
module text_console_writer_with_scroll_unit_tb;

    localparam int SCR_COLS    = 80;
    localparam int SCR_ROWS    = 25;
    localparam int RAND_ITEMS  = 1250;
    localparam int PHASES      = 6;
    localparam int SETTLE      = SCR_COLS + 20;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PRINT_CAP   = 40;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [7:0]       i_cfg_wdata = '0;
    logic             start       = 1'b0;
    logic             busy;
    tcw_pkg::t_item   i_item      = '0;
    logic             o_done;
    tcw_pkg::t_result o_result;

    // model of the console
    logic [tcw_pkg::CELL_W-1:0]       screen_img [SCR_ROWS][SCR_COLS];
    logic [tcw_pkg::CURSOR_COL_W-1:0] cur_col;
    logic [tcw_pkg::CURSOR_ROW_W-1:0] cur_row;
    logic [tcw_pkg::ATTR_W-1:0]       text_attr;

    tcw_pkg::t_result cell_queue [$];

    typedef struct {
        tcw_pkg::t_item   it;
        bit               known;
        tcw_pkg::t_result want;
    } t_dir_row;
    t_dir_row dir_rows [$];

    int n_faults   = 0;
    int n_results  = 0;
    int n_cycles   = 0;
    int n_puts     = 0;
    int n_newlines = 0;
    int n_reads    = 0;
    int n_off_scr  = 0;
    int n_wraps    = 0;
    int n_scrolls  = 0;
    bit no_idle    = 1'b0;

    text_console_writer_with_scroll_unit #(
        .COLUMNS (SCR_COLS),
        .ROWS    (SCR_ROWS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    always begin
        #5;
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     n_cycles, cell_queue.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report_fault(input string msg);
        if (n_faults < PRINT_CAP)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        n_faults++;
    endtask

    function automatic tcw_pkg::t_result console_step(input tcw_pkg::t_item it);
        tcw_pkg::t_result           r;
        int                         row;
        int                         col;
        logic [tcw_pkg::CELL_W-1:0] cell_v;
        if (it.action == tcw_pkg::ACT_PUT) begin
            n_puts++;
            if (it.char_code == tcw_pkg::NEWLINE_BYTE) begin
                n_newlines++;
                cur_col = '0;
                cur_row = cur_row + 1'b1;
            end else begin
                screen_img[cur_row][cur_col] = {text_attr, it.char_code};
                cur_col = cur_col + 1'b1;
                if (cur_col >= SCR_COLS) begin
                    n_wraps++;
                    cur_col = '0;
                    cur_row = cur_row + 1'b1;
                end
            end
            if (cur_row >= SCR_ROWS) begin
                n_scrolls++;
                for (int r_i = 0; r_i < SCR_ROWS - 1; r_i++)
                    for (int c_i = 0; c_i < SCR_COLS; c_i++)
                        screen_img[r_i][c_i] = screen_img[r_i + 1][c_i];
                for (int c_i = 0; c_i < SCR_COLS; c_i++)
                    screen_img[SCR_ROWS - 1][c_i] = tcw_pkg::BLANK_CELL;
                cur_row = tcw_pkg::CURSOR_ROW_W'(SCR_ROWS - 1);
            end
            row = cur_row;
            col = cur_col;
        end else begin
            n_reads++;
            row = it.read_row;
            col = it.read_col;
        end
        if (row < SCR_ROWS && col < SCR_COLS) begin
            cell_v = screen_img[row][col];
        end else begin
            n_off_scr++;
            cell_v = '0;
        end
        r.cell_char  = cell_v[tcw_pkg::CHAR_W-1:0];
        r.cell_attr  = cell_v[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
        r.cursor_col = cur_col;
        r.cursor_row = cur_row;
        return r;
    endfunction

    always @(posedge i_clk) begin : result_check
        tcw_pkg::t_result want;
        if (i_rst_n && o_done) begin
            n_results++;
            if (cell_queue.size() == 0) begin
                report_fault($sformatf("result beat %h with none expected", o_result));
            end else begin
                want = cell_queue.pop_front();
                if (o_result.cell_char !== want.cell_char)
                    report_fault($sformatf("cell_char %h, expected %h",
                                           o_result.cell_char, want.cell_char));
                if (o_result.cell_attr !== want.cell_attr)
                    report_fault($sformatf("cell_attr %h, expected %h",
                                           o_result.cell_attr, want.cell_attr));
                if (o_result.cursor_col !== want.cursor_col)
                    report_fault($sformatf("cursor_col %0d, expected %0d",
                                           o_result.cursor_col, want.cursor_col));
                if (o_result.cursor_row !== want.cursor_row)
                    report_fault($sformatf("cursor_row %0d, expected %0d",
                                           o_result.cursor_row, want.cursor_row));
            end
        end
    end

    task automatic send_item(input tcw_pkg::t_item it, input bit known,
                             input tcw_pkg::t_result typed);
        int               gap;
        tcw_pkg::t_result pred;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        pred = console_step(it);
        cell_queue.push_back(known ? typed : pred);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (cell_queue.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_attr(input logic [tcw_pkg::ATTR_W-1:0] v);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        text_attr = v;
    endtask

    task automatic add_row(input logic act, input logic [7:0] ch, input logic [4:0] row,
                           input logic [6:0] col, input bit known,
                           input tcw_pkg::t_result want);
        t_dir_row d;
        d.it.action    = act;
        d.it.char_code = ch;
        d.it.read_row  = row;
        d.it.read_col  = col;
        d.known        = known;
        d.want         = want;
        dir_rows.push_back(d);
    endtask

    function automatic tcw_pkg::t_item random_item();
        tcw_pkg::t_item it;
        int             pick;
        it.action    = tcw_pkg::ACT_PUT;
        it.char_code = tcw_pkg::CHAR_W'($urandom);
        it.read_row  = tcw_pkg::CURSOR_ROW_W'($urandom);
        it.read_col  = tcw_pkg::CURSOR_COL_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            it.char_code = tcw_pkg::NEWLINE_BYTE;
        end else if (pick >= 62) begin
            it.action = tcw_pkg::ACT_READ;
            if (pick < 80) begin
                it.read_row = tcw_pkg::CURSOR_ROW_W'($urandom_range(0, SCR_ROWS - 1));
                it.read_col = tcw_pkg::CURSOR_COL_W'($urandom_range(0, SCR_COLS - 1));
            end else if (pick < 92) begin
                it.read_row = cur_row;
                it.read_col = tcw_pkg::CURSOR_COL_W'($urandom_range(0, SCR_COLS - 1));
            end
        end
        return it;
    endfunction

    initial begin
        tcw_pkg::t_item it;
        logic [7:0]     attr_v;
        int             per_phase;

        for (int r_i = 0; r_i < SCR_ROWS; r_i++)
            for (int c_i = 0; c_i < SCR_COLS; c_i++)
                screen_img[r_i][c_i] = tcw_pkg::BLANK_CELL;
        cur_col   = '0;
        cur_row   = '0;
        text_attr = tcw_pkg::ATTR_RESET;

        // fresh screen, then off-screen corners
        add_row(tcw_pkg::ACT_READ, 8'h00, 5'd0,  7'd0,   1'b1, {8'h20, 8'h07, 7'd0, 5'd0});
        add_row(tcw_pkg::ACT_READ, 8'hFF, 5'd24, 7'd79,  1'b1, {8'h20, 8'h07, 7'd0, 5'd0});
        add_row(tcw_pkg::ACT_READ, 8'hFF, 5'd31, 7'd127, 1'b1, '0);
        add_row(tcw_pkg::ACT_READ, 8'h00, 5'd25, 7'd0,   1'b1, '0);
        add_row(tcw_pkg::ACT_READ, 8'h00, 5'd0,  7'd80,  1'b1, '0);
        // puts: plain, high bytes, zero, neighbours of newline
        add_row(tcw_pkg::ACT_PUT,  8'h41, 5'd31, 7'd127, 1'b0, '0);
        add_row(tcw_pkg::ACT_PUT,  8'hFF, 5'd0,  7'd0,   1'b0, '0);
        add_row(tcw_pkg::ACT_PUT,  8'h00, 5'd0,  7'd0,   1'b0, '0);
        add_row(tcw_pkg::ACT_PUT,  8'h80, 5'd0,  7'd0,   1'b0, '0);
        add_row(tcw_pkg::ACT_PUT,  8'h7F, 5'd0,  7'd0,   1'b0, '0);
        add_row(tcw_pkg::ACT_READ, 8'h00, 5'd0,  7'd0,   1'b0, '0);
        add_row(tcw_pkg::ACT_READ, 8'h00, 5'd0,  7'd1,   1'b0, '0);
        add_row(tcw_pkg::ACT_PUT,  tcw_pkg::NEWLINE_BYTE, 5'd0, 7'd0, 1'b0, '0);
        add_row(tcw_pkg::ACT_PUT,  8'h0B, 5'd0,  7'd0,   1'b0, '0);
        add_row(tcw_pkg::ACT_PUT,  8'h09, 5'd0,  7'd0,   1'b0, '0);
        add_row(tcw_pkg::ACT_READ, 8'h00, 5'd1,  7'd0,   1'b0, '0);
        add_row(tcw_pkg::ACT_READ, 8'h00, 5'd1,  7'd1,   1'b0, '0);
        add_row(tcw_pkg::ACT_READ, 8'h00, 5'd1,  7'd2,   1'b0, '0);
        add_row(tcw_pkg::ACT_PUT,  tcw_pkg::NEWLINE_BYTE, 5'd0, 7'd0, 1'b0, '0);
        add_row(tcw_pkg::ACT_PUT,  tcw_pkg::NEWLINE_BYTE, 5'd0, 7'd0, 1'b0, '0);
        add_row(tcw_pkg::ACT_READ, 8'h00, 5'd31, 7'd0,   1'b0, '0);
        add_row(tcw_pkg::ACT_READ, 8'h00, 5'd0,  7'd127, 1'b0, '0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        foreach (dir_rows[n])
            send_item(dir_rows[n].it, dir_rows[n].known, dir_rows[n].want);

        per_phase = RAND_ITEMS / PHASES;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       attr_v = 8'h00;
                1:       attr_v = 8'hFF;
                3:       attr_v = 8'h80;
                5:       attr_v = tcw_pkg::ATTR_RESET;
                default: attr_v = 8'($urandom);
            endcase
            write_attr(attr_v);
            for (int k = 0; k < per_phase; k++) begin
                if (k % 40 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                it = random_item();
                send_item(it, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (cell_queue.size() != 0)
            report_fault($sformatf("%0d result beats never arrived", cell_queue.size()));

        $display("covered %0d puts (%0d newlines, %0d wraps, %0d scrolls), %0d reads",
                 n_puts, n_newlines, n_wraps, n_scrolls, n_reads);
        $display("%0d off-screen cells, %0d result beats checked, %0d faults",
                 n_off_scr, n_results, n_faults);
        if (n_faults == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
